// ===== rtl/core/linear_probe_hash_table_defines.svh =====
// assertion macros for the linear probe hash table checker
// no dependencies; expects clk_i and rst_ni in the scope of each use
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LPHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lpht_pkg.sv =====
// shared constants, codes and helper functions of the linear probe hash table
// no dependencies
package lpht_pkg;

  localparam int SLOT_ADDR_BITS = 10;
  localparam int DEPTH          = 1 << SLOT_ADDR_BITS;
  localparam int HASH_W         = 32;
  localparam int KEY_W          = 2 * HASH_W;
  localparam int CNT_W          = SLOT_ADDR_BITS + 1;
  localparam int SIZE_W         = 4;
  localparam int MODE_W         = 2;
  localparam int STATUS_W       = 2;
  localparam int OUT_W          = SLOT_ADDR_BITS + STATUS_W + CNT_W + 2;
  localparam int OUT_TDATA_W    = ((OUT_W + 7) / 8) * 8;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  // slot mask for the size register, size clamped to 1..SLOT_ADDR_BITS
  function automatic logic [SLOT_ADDR_BITS-1:0] slot_mask(input logic [SIZE_W-1:0] size);
    int l;
    logic [SLOT_ADDR_BITS-1:0] m;
    l = int'(size);
    if (l < 1) l = 1;
    if (l > SLOT_ADDR_BITS) l = SLOT_ADDR_BITS;
    for (int i = 0; i < SLOT_ADDR_BITS; i++) begin
      m[i] = (i < l);
    end
    return m;
  endfunction

  // slot count in use
  function automatic logic [CNT_W-1:0] slot_cap(input logic [SIZE_W-1:0] size);
    return {1'b0, slot_mask(size)} + 1'b1;
  endfunction

endpackage

// ===== rtl/core/linear_probe_hash_table.sv =====
// linear probe hash table top level: sequencer, slot store and result register
// depends on lpht_pkg and lpht_ram
//
//   channel  | dir | handshake                     | beat contents
//   ---------+-----+-------------------------------+------------------------------------
//   s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser mode, tdata key_hash_a, key_hash_b
//   m_axis   | out | m_axis_tvalid / m_axis_tready | tdata slot, status, used_count, flags
//   cfg      | in  | cfg_valid_i / cfg_ready_o     | cfg_data_i size_log2
//
// after reset a clearing pass over all 1024 slots empties the store; s_axis_tready stays low.
// insert, lookup and delete pass S_LOOK, then make p probes in S_CHECK (1 per cycle,
// 1..2^size_log2, size_log2 clamped to 1..10), paced by the single read port of the slot store
// walked one slot a cycle, then S_DONE. clear writes one slot per cycle over the whole store.
// a zero key goes straight to S_DONE as a miss. one item at a time; the next beat is taken while a
// result waits in the output register, which holds until m_axis_tready.
module linear_probe_hash_table import lpht_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [KEY_W-1:0]       s_axis_tdata,   // key_hash_a, key_hash_b
  input  logic [MODE_W-1:0]      s_axis_tuser,   // mode
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // slot, status, used_count, is_full,
                                                 // is_empty, zero fill
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [SIZE_W-1:0]      cfg_data_i
);

  localparam int A = SLOT_ADDR_BITS;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [SIZE_W-1:0]      size_q;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  mode_e                  mode_q, mode_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [A-1:0]           pos_q, pos_d;
  logic [A-1:0]           n_q, n_d;
  logic [A-1:0]           clr_q, clr_d;
  logic [A-1:0]           res_slot_q, res_slot_d;
  status_e                res_status_q, res_status_d;

  logic [A-1:0]     mask;
  logic [A-1:0]     pos_inc;
  logic [A-1:0]     rd_addr;
  logic [KEY_W-1:0] rd_data;
  logic             we;
  logic [A-1:0]     waddr;
  logic [KEY_W-1:0] wdata;
  logic             hit, empty, last;
  logic             in_beat;
  logic [OUT_W-1:0] result;

  assign mask    = slot_mask(size_q);
  assign pos_inc = (pos_q + 1'b1) & mask;
  // while checking, fetch the next slot so probes run one per cycle
  assign rd_addr = (state_q == S_CHECK) ? pos_inc : pos_q;
  assign hit     = (rd_data == key_q);
  assign empty   = (rd_data == '0);
  assign last    = (n_q == mask);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign result = {(cnt_q == '0), (cnt_q == slot_cap(size_q)), cnt_q, res_status_q, res_slot_q};

  lpht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    mode_d       = mode_q;
    key_d        = key_q;
    pos_d        = pos_q;
    n_d          = n_q;
    clr_d        = clr_q;
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    we           = 1'b0;
    waddr        = pos_q;
    wdata        = key_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT, S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          if (state_q == S_INIT) begin
            state_d = S_IDLE;
          end else begin
            res_slot_d   = '0;
            res_status_d = ST_OK;
            cnt_d        = '0;
            state_d      = S_DONE;
          end
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          mode_d = mode_e'(s_axis_tuser);
          // key_hash_a is the upper half of the stored pair
          key_d  = {s_axis_tdata[HASH_W-1:0], s_axis_tdata[KEY_W-1:HASH_W]};
          pos_d  = s_axis_tdata[A-1:0] & mask;
          n_d    = '0;
          clr_d  = '0;
          if (mode_e'(s_axis_tuser) == MODE_CLEAR) begin
            state_d = S_CLEAR;
          end else if (s_axis_tdata == '0) begin
            res_slot_d   = '0;
            res_status_d = ST_MISS;
            state_d      = S_DONE;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (mode_q == MODE_INSERT) begin
          if (empty) begin
            we           = 1'b1;
            res_slot_d   = pos_q;
            res_status_d = ST_OK;
            if (!(&cnt_q)) cnt_d = cnt_q + 1'b1;
            state_d      = S_DONE;
          end else if (hit) begin
            res_slot_d   = '0;
            res_status_d = ST_DUP;
            state_d      = S_DONE;
          end else if (last) begin
            res_slot_d   = '0;
            res_status_d = ST_FULL;
            state_d      = S_DONE;
          end else begin
            pos_d = pos_inc;
            n_d   = n_q + 1'b1;
          end
        end else begin
          if (hit) begin
            res_slot_d   = pos_q;
            res_status_d = ST_OK;
            if (mode_q == MODE_DELETE) begin
              we    = 1'b1;
              wdata = '0;
              if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
            end
            state_d = S_DONE;
          end else if (empty || last) begin
            res_slot_d   = '0;
            res_status_d = ST_MISS;
            state_d      = S_DONE;
          end else begin
            pos_d = pos_inc;
            n_d   = n_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_TDATA_W'(result);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      size_q      <= SIZE_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        size_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    mode_q       <= mode_d;
    key_q        <= key_d;
    pos_q        <= pos_d;
    n_q          <= n_d;
    res_slot_q   <= res_slot_d;
    res_status_q <= res_status_d;
  end

endmodule

// ===== rtl/core/lpht_ram.sv =====
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module lpht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lpht_chk.sv =====
// port-level checker for the linear probe hash table, bound to the top level
// depends on lpht_pkg and linear_probe_hash_table_defines.svh
`include "linear_probe_hash_table_defines.svh"

module lpht_chk import lpht_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [SLOT_ADDR_BITS-1:0] slot;
  logic [STATUS_W-1:0]       status;
  logic [CNT_W-1:0]          cnt;
  logic                      is_empty;
  logic                      failed;
  logic                      stall;

  assign slot     = m_axis_tdata[SLOT_ADDR_BITS-1:0];
  assign status   = m_axis_tdata[SLOT_ADDR_BITS +: STATUS_W];
  assign cnt      = m_axis_tdata[SLOT_ADDR_BITS + STATUS_W +: CNT_W];
  assign is_empty = m_axis_tdata[SLOT_ADDR_BITS + STATUS_W + CNT_W + 1];
  assign failed   = m_axis_tvalid && (status != ST_OK);
  assign stall    = m_axis_tvalid && !m_axis_tready;

  // failed operations report slot zero
  `LPHT_ASSERT_NOW(a_slot_zero, failed, slot == '0, "slot set on failure")

  `LPHT_ASSERT_NOW(a_empty_flag, m_axis_tvalid, is_empty == (cnt == '0), "empty flag mismatch")

  // the count never exceeds the store depth
  `LPHT_ASSERT_NOW(a_cnt_bound, m_axis_tvalid, cnt <= CNT_W'(DEPTH), "count beyond depth")

  `LPHT_ASSERT_NEXT(a_out_hold, stall, m_axis_tvalid && $stable(m_axis_tdata), "beat changed")

endmodule

bind linear_probe_hash_table lpht_chk u_lpht_chk (.*);
